>>> src/slid_pkg.sv
// package for the sorted list insert/delete core
// holds field widths, operation and status codes, and the cell control type
// no dependencies
package slid_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int HELD_W       = 6;
  localparam int CAPACITY_DEF = 32;

  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE    = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_UP   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_DOWN = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_UP,
    CELL_ROT_DOWN
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage

>>> src/slid_if.sv
// request and response channel interfaces of the sorted list core
// depends on slid_pkg
interface slid_req_if import slid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

interface slid_rsp_if import slid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;
  logic [HELD_W-1:0]        entries_held;

  modport source (output valid, data_value, status, last, entries_held, input ready);
  modport sink (input valid, data_value, status, last, entries_held, output ready);
endinterface

>>> src/slid_cell.sv
// one slot of the sorted chain: holds a value, compares it with the operand
// and takes the operand or a neighbor's value on insert, delete or rotation; uses slid_pkg
module slid_cell import slid_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occupied,
  input  logic                     is_tail,
  input  logic signed [DATA_W-1:0] prev_value,
  input  logic                     prev_less,
  input  logic signed [DATA_W-1:0] next_value,
  input  logic signed [DATA_W-1:0] head_value,
  input  logic                     found,
  output logic signed [DATA_W-1:0] value,
  output logic                     less,
  output logic                     hit
);

  logic signed [DATA_W-1:0] value_next;

  assign less = occupied && (value < ctl.val);
  // any stored entry equal to the operand
  assign hit  = occupied && (value == ctl.val);

  always_comb begin
    value_next = value;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (!less) begin
          value_next = prev_less ? ctl.val : prev_value;
        end
      end
      CELL_DELETE: begin
        if (!less && found) begin
          value_next = next_value;
        end
      end
      CELL_ROT_UP:   value_next = is_tail ? head_value : next_value;
      CELL_ROT_DOWN: value_next = prev_value;
      default:       value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> src/sorted_list_insert_delete_core.sv
// Sorted list core: keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells. Insert and delete update all cells in parallel, so such a request is answered in the
// cycle after it is taken and a new request may follow in the next cycle (one request per
// cycle when the response is taken at once). A read streams the entries one per cycle while
// the response is taken at once, by rotating the chain one step per entry, after which the
// chain is back in its original order; an empty list gives one response with status empty. A
// full list drops an inserted value and a missing value on delete gives status not found.
// Only one request is in work at a time.
// depends on slid_pkg, slid_if and slid_cell
module sorted_list_insert_delete_core import slid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  slid_req_if.sink    req,
  slid_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_down;
  logic                     o_valid;
  logic signed [DATA_W-1:0] o_data;
  logic [STATUS_W-1:0]      o_status;
  logic                     o_last;
  logic [HELD_W-1:0]        o_held;

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]      cell_less;
  logic [CAPACITY-1:0]      cell_hit;
  logic [IDX_W-1:0]         tail_idx;
  logic signed [DATA_W-1:0] tail_value;
  logic                     found;
  logic                     out_free;
  logic                     accept;
  logic                     is_full;
  cell_ctl_t                ctl;
  logic [CNT_W-1:0]         count_next;

  assign out_free   = !o_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign is_full    = (count == CNT_W'(CAPACITY));
  assign found      = |cell_hit;
  assign tail_idx   = IDX_W'(count - 1'b1);
  assign tail_value = cell_value[tail_idx];

  always_comb begin
    ctl.val    = req.value;
    ctl.cmd    = CELL_HOLD;
    count_next = count;
    if (state == S_IDLE) begin
      if (accept && req.operation == OP_INSERT && !is_full) begin
        ctl.cmd    = CELL_INSERT;
        count_next = count + 1'b1;
      end else if (accept && req.operation == OP_DELETE && found) begin
        ctl.cmd    = CELL_DELETE;
        count_next = count - 1'b1;
      end
    end else if (out_free) begin
      ctl.cmd = rd_down ? CELL_ROT_DOWN : CELL_ROT_UP;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_v;
    logic signed [DATA_W-1:0] next_v;
    logic                     prev_l;
    if (i == 0) begin : g_head
      // head takes the operand on insert and the tail on a downward rotation
      assign prev_v = (ctl.cmd == CELL_ROT_DOWN) ? tail_value : ctl.val;
      assign prev_l = 1'b0;
    end else begin : g_body
      assign prev_v = cell_value[i-1];
      assign prev_l = cell_less[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_v = cell_value[i];
    end else begin : g_mid
      assign next_v = cell_value[i+1];
    end

    slid_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < count),
      .is_tail    (IDX_W'(i) == tail_idx),
      .prev_value (prev_v),
      .prev_less  (prev_l),
      .next_value (next_v),
      .head_value (cell_value[0]),
      .found      (found),
      .value      (cell_value[i]),
      .less       (cell_less[i]),
      .hit        (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_idx  <= '0;
      rd_down <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            o_last <= 1'b1;
            o_held <= HELD_W'(count_next);
            case (req.operation)
              OP_INSERT: begin
                o_valid  <= 1'b1;
                o_data   <= req.value;
                o_status <= is_full ? ST_FULL : ST_OK;
              end
              OP_DELETE: begin
                o_valid  <= 1'b1;
                o_data   <= req.value;
                o_status <= found ? ST_OK : ST_NOT_FOUND;
              end
              default: begin
                if (count == '0) begin
                  o_valid  <= 1'b1;
                  o_status <= ST_EMPTY;
                  o_data   <= '0;
                end else begin
                  o_valid <= 1'b0;
                  rd_idx  <= '0;
                  rd_down <= (req.operation == OP_READ_DOWN);
                  state   <= S_READ;
                end
              end
            endcase
          end else if (out_free) begin
            o_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_data   <= rd_down ? tail_value : cell_value[0];
            o_status <= ST_OK;
            o_held   <= HELD_W'(count);
            o_last   <= (rd_idx == tail_idx);
            rd_idx   <= rd_idx + 1'b1;
            if (rd_idx == tail_idx) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.data_value   = o_data;
  assign rsp.status       = o_status;
  assign rsp.last         = o_last;
  assign rsp.entries_held = o_held;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_req_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !req.ready)
    else $error("request taken during read-out");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_INSERT && !is_full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("entry count changed during read-out");

endmodule

>>> verif/sorted_list_checker.sv
// checker for the sorted list core: watches the request and response channels,
// keeps its own copy of the sorted list, predicts every response and compares it
// depends on slid_pkg and slid_if
module sorted_list_checker import slid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  slid_req_if  req,
  slid_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data_value;
    logic [STATUS_W-1:0]      status;
    logic                     last;
    logic [HELD_W-1:0]        entries_held;
  } list_rsp_t;

  logic signed [DATA_W-1:0] held_values[$];
  list_rsp_t                awaited_rsp[$];
  list_rsp_t                want;
  int                       errors;

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
  endtask

  // updates the list copy and queues the responses one request causes
  task automatic apply_list_request(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] val);
    list_rsp_t r;
    int        pos;
    int        n;
    n = held_values.size();
    r.data_value = val;
    r.status     = ST_OK;
    r.last       = 1'b1;
    case (op)
      OP_INSERT: begin
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal values go before the ones already stored
          pos = 0;
          while (pos < n && held_values[pos] < val) pos++;
          held_values.insert(pos, val);
        end
        r.entries_held = HELD_W'(held_values.size());
        awaited_rsp.push_back(r);
      end
      OP_DELETE: begin
        pos = 0;
        while (pos < n && held_values[pos] != val) pos++;
        if (pos >= n) begin
          r.status = ST_NOT_FOUND;
        end else begin
          held_values.delete(pos);
        end
        r.entries_held = HELD_W'(held_values.size());
        awaited_rsp.push_back(r);
      end
      default: begin
        if (n == 0) begin
          r.data_value   = '0;
          r.status       = ST_EMPTY;
          r.entries_held = '0;
          awaited_rsp.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.data_value   = (op == OP_READ_UP) ? held_values[i] : held_values[n-1-i];
            r.last         = (i == n - 1);
            r.entries_held = HELD_W'(n);
            awaited_rsp.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_values.delete();
      awaited_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsp.size() == 0) begin
          flag_mismatch("unexpected response data_value", 0, longint'(rsp.data_value));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.data_value !== want.data_value)
            flag_mismatch("data_value", longint'(want.data_value), longint'(rsp.data_value));
          if (rsp.status !== want.status)
            flag_mismatch("status", longint'(want.status), longint'(rsp.status));
          if (rsp.last !== want.last)
            flag_mismatch("last", longint'(want.last), longint'(rsp.last));
          if (rsp.entries_held !== want.entries_held)
            flag_mismatch("entries_held", longint'(want.entries_held),
                          longint'(rsp.entries_held));
        end
      end
      if (req.valid && req.ready) apply_list_request(req.operation, req.value);
    end
    mismatches  <= errors;
    outstanding <= awaited_rsp.size();
  end

endmodule

>>> verif/sorted_list_insert_delete_core_test.sv
// top of the sorted list core testbench: clock, reset, request stimulus,
// response back-pressure and the final verdict
// depends on slid_pkg, slid_if, sorted_list_checker and sorted_list_insert_delete_core
module sorted_list_insert_delete_core_test;
  import slid_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int RANDOM_REQS = 380;
  localparam int PHASE_LEN   = 48;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  bit   steady_flow;

  logic signed [DATA_W-1:0] inserted_log[$];

  slid_req_if req_ch ();
  slid_rsp_if rsp_ch ();

  sorted_list_insert_delete_core #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // response side: random stall before each response, none in steady phases
  initial begin
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_all_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -32'sd1;
          default: v = 32'sh8000_0001;
        endcase
      end
      default: v = $signed($urandom_range(0, 20)) - 32'sd10;
    endcase
    return v;
  endfunction

  initial begin
    int                       n;
    int                       roll;
    int                       idx;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;

    steady_flow      = 1'b0;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_INSERT;
    req_ch.value     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, duplicates, misses, both read orders
    send_request(OP_READ_UP, $urandom);
    send_request(OP_READ_DOWN, $urandom);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_READ_UP, $urandom);
    send_request(OP_READ_DOWN, $urandom);
    send_request(OP_DELETE, 32'sd7);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sh8000_0000);
    send_request(OP_DELETE, 32'sh7fff_ffff);
    send_request(OP_READ_UP, $urandom);
    send_request(OP_DELETE, -32'sd1);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sh7fff_ffff);
    send_request(OP_READ_DOWN, $urandom);
    send_request(OP_INSERT, 32'sh5555_5555);
    send_request(OP_INSERT, 32'shaaaa_aaaa);
    send_request(OP_READ_UP, $urandom);
    send_request(OP_DELETE, 32'sh5555_5555);

    // random: alternate filling phases (reach full, overflow) and draining phases
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % PHASE_LEN == 0) begin
        wait_all_responses();
        steady_flow = ((n / PHASE_LEN) % 3 == 2);
      end
      roll = $urandom_range(0, 99);
      if ((n / PHASE_LEN) % 2 == 0) begin
        op = (roll < 82) ? OP_INSERT : (roll < 88) ? OP_DELETE :
             (roll < 94) ? OP_READ_UP : OP_READ_DOWN;
      end else begin
        op = (roll < 78) ? OP_DELETE : (roll < 84) ? OP_INSERT :
             (roll < 92) ? OP_READ_UP : OP_READ_DOWN;
      end
      if (op == OP_INSERT) begin
        val = pick_value();
        inserted_log.push_back(val);
      end else if (op == OP_DELETE && inserted_log.size() > 0 && roll % 8 != 0) begin
        // mostly delete something that was inserted, sometimes a likely miss
        idx = $urandom_range(0, inserted_log.size() - 1);
        val = inserted_log[idx];
        inserted_log.delete(idx);
      end else begin
        val = pick_value();
      end
      send_request(op, val);
    end

    wait_all_responses();
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
